>>> src/humidity_sensor_frame_decoder_assert.svh
// Assertion macros used by the checker file of the frame decoder.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define HSFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define HSFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/hsfd_pkg.sv
`timescale 1ns / 1ps

package hsfd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               temp_crc_ok;
    logic               hum_crc_ok;
  } out_t;

  // Position of a byte within the six-byte frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  localparam logic [7:0]  CRC_INIT     = 8'hFF;
  localparam logic [7:0]  CRC_POLY_LOW = 8'h31;
  localparam logic [15:0] STATUS_MASK  = 16'h0003;
  localparam logic [15:0] FULL_SCALE   = 16'hFFFF;
  localparam logic [14:0] TEMP_SPAN    = 15'd17500;
  localparam logic [14:0] HUM_SPAN     = 15'd10000;
  localparam logic [14:0] TEMP_OFFSET  = 15'd4500;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY_LOW;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/humidity_sensor_frame_decoder.sv
`timescale 1ns / 1ps

// The sixth frame byte becomes a result beat through the input and output registers.
// Throughput: one byte beat per cycle; a waiting result stalls input only when the
// input register also holds a sixth byte.
// Reset (rst, synchronous, active high) empties both registers, restarts the frame
// position and sets the held temperature and humidity to zero.
module humidity_sensor_frame_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsfd_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsfd_pkg::out_t   out_data
);

  // Input register: one byte beat waits here to be decoded.
  logic                 a_valid;
  hsfd_pkg::in_t        a_item;

  // Frame state.
  hsfd_pkg::pos_t       pos;
  hsfd_pkg::pos_t       pos_next;
  hsfd_pkg::pos_t       cur_pos;
  logic [7:0]           crc;
  logic [7:0]           crc_next;
  logic [7:0]           hi;
  logic [7:0]           hi_next;
  logic [30:0]          prod;
  logic [30:0]          prod_next;
  logic                 temp_good;
  logic                 temp_good_next;
  logic signed [14:0]   held_temp;
  logic signed [14:0]   held_temp_next;
  logic [13:0]          held_hum;
  logic [13:0]          held_hum_next;

  logic                 a_makes;
  logic                 a_go;
  logic                 match;
  logic [15:0]          raw;
  logic [14:0]          span;
  logic [14:0]          quot;
  logic [14:0]          temp_val;
  hsfd_pkg::out_t       result;

  // A frame mark restarts the position, so the byte is always a temperature high byte.
  assign cur_pos = a_item.frame_start ? hsfd_pkg::POS_T_HI : pos;

  // Only the humidity CRC byte yields a result, so only it waits on the output side.
  assign a_makes  = (cur_pos == hsfd_pkg::POS_H_CRC);
  assign a_go     = a_valid && (!a_makes || !out_valid || out_ready);
  assign in_ready = !a_valid || a_go;

  assign match = (crc == a_item.rx_byte);

  // The low data byte arrives now; the two status bits are cleared.
  assign raw  = {hi, a_item.rx_byte} & ~hsfd_pkg::STATUS_MASK;
  assign span = (cur_pos == hsfd_pkg::POS_H_LO) ? hsfd_pkg::HUM_SPAN : hsfd_pkg::TEMP_SPAN;

  // The product of span and raw word is registered when the low byte comes in, so the
  // CRC byte cycle only does the divide by full scale and the compare.
  hsfd_scale u_scale (
    .prod (prod),
    .quot (quot)
  );

  // The quotient stays below 17500, so the offset result fits 15 bits signed.
  assign temp_val = quot - hsfd_pkg::TEMP_OFFSET;

  always_comb begin
    pos_next       = pos;
    crc_next       = crc;
    hi_next        = hi;
    prod_next      = prod;
    temp_good_next = temp_good;
    held_temp_next = held_temp;
    held_hum_next  = held_hum;
    unique case (cur_pos) inside
      hsfd_pkg::POS_T_HI, hsfd_pkg::POS_H_HI: begin
        hi_next  = a_item.rx_byte;
        crc_next = hsfd_pkg::crc8_step(hsfd_pkg::CRC_INIT, a_item.rx_byte);
        pos_next = (cur_pos == hsfd_pkg::POS_T_HI) ? hsfd_pkg::POS_T_LO : hsfd_pkg::POS_H_LO;
      end
      hsfd_pkg::POS_T_LO, hsfd_pkg::POS_H_LO: begin
        crc_next  = hsfd_pkg::crc8_step(crc, a_item.rx_byte);
        prod_next = 31'(span * raw);
        pos_next  = (cur_pos == hsfd_pkg::POS_T_LO) ? hsfd_pkg::POS_T_CRC : hsfd_pkg::POS_H_CRC;
      end
      hsfd_pkg::POS_T_CRC: begin
        temp_good_next = match;
        if (match) begin
          held_temp_next = temp_val;
        end
        pos_next = hsfd_pkg::POS_H_HI;
      end
      hsfd_pkg::POS_H_CRC: begin
        if (match) begin
          held_hum_next = quot[13:0];
        end
        pos_next = hsfd_pkg::POS_T_HI;
      end
      default: begin
        // Unused position codes behave as the start of a frame.
        hi_next  = a_item.rx_byte;
        crc_next = hsfd_pkg::crc8_step(hsfd_pkg::CRC_INIT, a_item.rx_byte);
        pos_next = hsfd_pkg::POS_T_LO;
      end
    endcase
  end

  // The result carries the temperature held at this point of the frame and the
  // humidity after this word's update.
  always_comb begin
    result.temperature_centi = held_temp;
    result.humidity_centi    = held_hum_next;
    result.temp_crc_ok       = temp_good;
    result.hum_crc_ok        = match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      pos       <= hsfd_pkg::POS_T_HI;
      crc       <= hsfd_pkg::CRC_INIT;
      hi        <= 8'd0;
      temp_good <= 1'b0;
      held_temp <= 15'sd0;
      held_hum  <= 14'd0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        a_item <= in_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (a_go) begin
        pos       <= pos_next;
        crc       <= crc_next;
        hi        <= hi_next;
        prod      <= prod_next;
        temp_good <= temp_good_next;
        held_temp <= held_temp_next;
        held_hum  <= held_hum_next;
        if (a_makes) begin
          out_valid <= 1'b1;
          out_data  <= result;
        end
      end
    end
  end

endmodule

>>> src/hsfd_scale.sv
`timescale 1ns / 1ps

// Divides a scaled word by 65535 with one correction step.
module hsfd_scale (
  input  logic [30:0] prod,
  output logic [14:0] quot
);

  logic [14:0] q0;
  logic [16:0] rem;

  // Since 65535 = 2^16 - 1, the remainder of the first guess is low half plus guess.
  assign q0   = prod[30:16];
  assign rem  = {1'b0, prod[15:0]} + {2'b00, q0};
  assign quot = q0 + {14'd0, (rem >= {1'b0, hsfd_pkg::FULL_SCALE})};

endmodule

>>> src/hsfd_checker.sv
`timescale 1ns / 1ps

`include "humidity_sensor_frame_decoder_assert.svh"

module hsfd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input hsfd_pkg::out_t out_data
);

  `HSFD_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result valid after reset")
  `HSFD_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `HSFD_ASSERT(a_rise_after_beat, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a byte two cycles before")
  `HSFD_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/tb_humidity_sensor_frame_decoder.sv
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder;

  // Number of random byte beats after the directed part.
  localparam int RANDOM_BYTES = 400;
  // Length of the long receiver hold-off that forces the input to stall.
  localparam int HOLD_CYCLES  = 300;
  // Cycles to wait once nothing is expected any more.
  localparam int DRAIN_CYCLES = 10;

  // Tracks the decoder state on its own and keeps the readings still owed by the block.
  class frame_reading_book;
    hsfd_pkg::out_t     expected_readings[$];
    int                 errors = 0;
    hsfd_pkg::pos_t     byte_pos = hsfd_pkg::POS_T_HI;
    logic [7:0]         crc_acc = hsfd_pkg::CRC_INIT;
    logic [7:0]         hi_byte = '0;
    logic [7:0]         lo_byte = '0;
    logic               temp_good = 1'b0;
    logic signed [14:0] last_temp = '0;
    logic [13:0]        last_hum = '0;

    // CRC-8, polynomial 0x31, one data bit at a time, MSB first.
    static function logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ data[i];
        c = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ hsfd_pkg::CRC_POLY_LOW;
        end
      end
      return c;
    endfunction

    // Data word with its two status bits cleared.
    function int status_free_word();
      logic [15:0] raw;
      raw = {hi_byte, lo_byte} & ~hsfd_pkg::STATUS_MASK;
      return int'(raw);
    endfunction

    function void take_byte(input hsfd_pkg::in_t beat);
      int             scaled;
      hsfd_pkg::out_t reading;
      if (beat.frame_start) begin
        byte_pos = hsfd_pkg::POS_T_HI;
      end
      case (byte_pos)
        hsfd_pkg::POS_T_HI, hsfd_pkg::POS_H_HI: begin
          hi_byte = beat.rx_byte;
          crc_acc = crc8_next(hsfd_pkg::CRC_INIT, beat.rx_byte);
        end
        hsfd_pkg::POS_T_LO, hsfd_pkg::POS_H_LO: begin
          lo_byte = beat.rx_byte;
          crc_acc = crc8_next(crc_acc, beat.rx_byte);
        end
        hsfd_pkg::POS_T_CRC: begin
          temp_good = (crc_acc == beat.rx_byte);
          if (temp_good) begin
            scaled = (int'(hsfd_pkg::TEMP_SPAN) * status_free_word())
                     / int'(hsfd_pkg::FULL_SCALE);
            last_temp = 15'(scaled - int'(hsfd_pkg::TEMP_OFFSET));
          end
        end
        default: begin
          reading.hum_crc_ok = (crc_acc == beat.rx_byte);
          if (reading.hum_crc_ok) begin
            scaled = (int'(hsfd_pkg::HUM_SPAN) * status_free_word())
                     / int'(hsfd_pkg::FULL_SCALE);
            last_hum = 14'(scaled);
          end
          reading.temperature_centi = last_temp;
          reading.humidity_centi = last_hum;
          reading.temp_crc_ok = temp_good;
          expected_readings.push_back(reading);
          byte_pos = hsfd_pkg::POS_T_HI;
          return;
        end
      endcase
      byte_pos = hsfd_pkg::pos_t'(byte_pos + 3'd1);
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reading(input hsfd_pkg::out_t got);
      hsfd_pkg::out_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected reading, expected none, actual temp %0d hum %0d",
                 $time, got.temperature_centi, got.humidity_centi);
        return;
      end
      want = expected_readings.pop_front();
      compare_field("temperature_centi", want.temperature_centi, got.temperature_centi);
      compare_field("humidity_centi", want.humidity_centi, got.humidity_centi);
      compare_field("temp_crc_ok", want.temp_crc_ok, got.temp_crc_ok);
      compare_field("hum_crc_ok", want.hum_crc_ok, got.hum_crc_ok);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  hsfd_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  hsfd_pkg::out_t out_data;

  frame_reading_book book;

  // Stimulus controls shared between the sender, the receiver and the main sequence.
  bit calm_tail = 1'b0;     // no idling on either side once set
  bit push_burst = 1'b0;    // sender offers back to back
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off
  bit hold_active = 1'b0;   // the receiver is in that hold-off
  int sent_count = 0;

  humidity_sensor_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Both handshakes are observed right at the rising edge, before any
  // nonblocking update of that edge lands, so the sampled values are the ones
  // the block saw. A result cannot come from a byte taken in the same cycle,
  // so the order of the two checks does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        book.check_reading(out_data);
      end
      if (in_valid && in_ready) begin
        book.take_byte(in_data);
      end
    end
  end

  // Offers one byte beat and returns at the edge where it is taken. A random
  // gap may come first; valid then drops for the gap and rises again in a
  // later step, so valid never sees two assignments in one step.
  task automatic send_byte(input logic [7:0] value, input logic mark);
    hsfd_pkg::in_t beat;
    if (!calm_tail && !push_burst && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    beat.rx_byte = value;
    beat.frame_start = mark;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Sends one six-byte frame. A word whose CRC is to fail gets its CRC byte
  // flipped by a nonzero random pattern, so it can never match by chance.
  task automatic send_frame(input logic [15:0] temp_raw, input logic [15:0] hum_raw,
                            input bit temp_ok, input bit hum_ok, input logic mark);
    logic [7:0] temp_crc;
    logic [7:0] hum_crc;
    temp_crc = frame_reading_book::crc8_next(
                 frame_reading_book::crc8_next(hsfd_pkg::CRC_INIT, temp_raw[15:8]),
                 temp_raw[7:0]);
    hum_crc = frame_reading_book::crc8_next(
                frame_reading_book::crc8_next(hsfd_pkg::CRC_INIT, hum_raw[15:8]),
                hum_raw[7:0]);
    if (!temp_ok) begin
      temp_crc = temp_crc ^ 8'($urandom_range(1, 255));
    end
    if (!hum_ok) begin
      hum_crc = hum_crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(temp_raw[15:8], mark);
    send_byte(temp_raw[7:0], 1'b0);
    send_byte(temp_crc, 1'b0);
    send_byte(hum_raw[15:8], 1'b0);
    send_byte(hum_raw[7:0], 1'b0);
    send_byte(hum_crc, 1'b0);
  endtask

  // Mostly uniform words, now and then one of the two ends of the range.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: random ready bursts and stall bursts, one long hold-off on
  // request, and steady ready once the tail of the run is reached.
  initial begin : result_sink
    out_ready <= 1'b0;
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        hold_active = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : main_sequence
    int  pick;
    int  part_len;
    bit  pressure_done;
    bit  misaligned;
    book = new;
    pressure_done = 1'b0;
    misaligned = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first frame fails both CRCs, so the reading must
    // still carry the reset values of zero with both flags low.
    send_frame(16'h6666, 16'h8000, 1'b0, 1'b0, 1'b1);
    // A lone marked byte, then a new marked frame: the partial frame is
    // dropped without a reading. This frame also hits the low temperature
    // end and the top humidity word.
    send_byte(8'hA5, 1'b1);
    send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    // No start mark at all: the position wrapped after the last frame. The
    // humidity word holds only status bits, so it must decode to zero.
    send_frame(16'hFFFF, 16'h0003, 1'b1, 1'b1, 1'b0);
    // Temperature fails while humidity passes: the top temperature must repeat.
    send_frame(16'h4000, 16'h7FFC, 1'b0, 1'b1, 1'b1);

    // Random part. Most traffic is well-formed frames with random words and
    // mostly good CRCs; the rest is broken frames and stray bytes.
    sent_count = 0;
    while (sent_count < RANDOM_BYTES) begin
      if (sent_count > RANDOM_BYTES * 3 / 4) begin
        calm_tail = 1'b1;
      end
      if (!pressure_done && sent_count >= RANDOM_BYTES / 2) begin
        // Stop offering, let the receiver start its hold-off, then push
        // frames back to back so the block fills up and stalls its input.
        pressure_done = 1'b1;
        in_valid <= 1'b0;
        hold_request = 1'b1;
        do @(posedge clk); while (!hold_active);
        push_burst = 1'b1;
        repeat (4) begin
          send_frame(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1);
        end
        push_burst = 1'b0;
        misaligned = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        send_frame(pick_word(), pick_word(), $urandom_range(0, 4) != 0,
                   $urandom_range(0, 4) != 0, misaligned || ($urandom_range(0, 3) != 0));
        misaligned = 1'b0;
      end else if (pick == 7) begin
        // Frame cut short; the next frame restarts it mid-way.
        part_len = $urandom_range(1, 5);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < part_len; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        misaligned = 1'b1;
      end else begin
        // Stray bytes with a random start mark.
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        misaligned = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("PASS humidity_sensor_frame_decoder");
    end else begin
      $display("FAIL humidity_sensor_frame_decoder");
    end
    $finish;
  end

  // Ends a run that does not finish in time with a failure.
  initial begin : watchdog
    #4_000_000;
    $display("FAIL humidity_sensor_frame_decoder");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/hsfd_pkg.sv
src/hsfd_scale.sv
src/humidity_sensor_frame_decoder.sv
src/hsfd_checker.sv
tb/tb_humidity_sensor_frame_decoder.sv
